FILE: hw/rtl/bbd_pkg.sv
// Shared types and constants for the dual boxcar beacon direction block.
`timescale 1ns / 1ps

package bbd_pkg;

  localparam int SAMPLE_W      = 10;   // ADC sample and threshold width
  localparam int SUM_OUT_W     = 13;   // reported window sum width
  localparam int CFG_IDX_W     = 1;
  localparam int DET_THR_RESET = 10;
  localparam int ARR_THR_RESET = 500;

  typedef enum logic [1:0] {
    DIR_FRONT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DETECT  = 1'd0,
    REG_ARRIVED = 1'd1
  } cfg_reg_t;

  // Threshold hits seen by one lane on its updated window sum.
  typedef struct packed {
    logic det_hit;
    logic arr_hit;
  } bbd_hit_t;

endpackage

FILE: hw/rtl/bbd_lane.sv
// One sensor lane: ring window, running sum and threshold compares.
`timescale 1ns / 1ps

module bbd_lane #(
  parameter int WINDOW = 5,
  parameter int SUM_W  = 13,
  parameter int SLOT_W = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [SLOT_W-1:0]             slot,
  input  logic [bbd_pkg::SAMPLE_W-1:0]  sample,
  input  logic [SUM_W-1:0]              det_lim,
  input  logic [SUM_W-1:0]              arr_lim,
  output logic [SUM_W-1:0]              total,
  output bbd_pkg::bbd_hit_t             hits
);
  import bbd_pkg::*;

  logic [SAMPLE_W-1:0] win_r [WINDOW];
  logic [SUM_W-1:0]    total_r;
  logic [SUM_W-1:0]    total_nxt;

  // oldest entry leaves, new sample enters
  assign total_nxt = total_r - SUM_W'(win_r[slot]) + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else if (load) begin
      total_r     <= total_nxt;
      win_r[slot] <= sample;
    end
  end

  assign total        = total_r;
  assign hits.det_hit = total_r > det_lim;
  assign hits.arr_hit = total_r > arr_lim;

endmodule

FILE: hw/rtl/bbd_merge.sv
// Merges the two lane results into direction and arrival.
`timescale 1ns / 1ps

module bbd_merge #(
  parameter int SUM_W = 13
) (
  input  bbd_pkg::bbd_hit_t  left_hits,
  input  bbd_pkg::bbd_hit_t  right_hits,
  input  logic [SUM_W-1:0]   left_total,
  input  logic [SUM_W-1:0]   right_total,
  output bbd_pkg::dir_t      direction,
  output logic               arrived
);
  import bbd_pkg::*;

  always_comb begin
    if (left_hits.det_hit && right_hits.det_hit) begin
      // both seen: larger sum wins, tie goes right
      direction = (left_total > right_total) ? DIR_LEFT : DIR_RIGHT;
    end else if (left_hits.det_hit) begin
      direction = DIR_LEFT;
    end else if (right_hits.det_hit) begin
      direction = DIR_RIGHT;
    end else begin
      direction = DIR_FRONT;
    end
  end

  assign arrived = left_hits.arr_hit || right_hits.arr_hit;

endmodule

FILE: hw/rtl/dual_boxcar_beacon_direction.sv
// Top level of the dual boxcar beacon direction block.
// Usage:
//   Input channel (in_valid/in_ready) transfers one left and one right 10-bit
//   ADC sample. Each transfer replaces the oldest entry of a WINDOW-deep
//   ring window per side and updates that side's running sum.
//   Output channel (out_valid/out_ready) transfers one result per input:
//   direction (front/left/right), arrived flag and both window sums
//   (low 13 bits). A side is detected when sum > detect_threshold*WINDOW;
//   arrival when either sum > arrival level*WINDOW.
//   Config port: cfg_we writes cfg_data[9:0] into register cfg_index
//   (0 detect, 1 arrived); the limits are stored premultiplied by WINDOW.
//   Write config only while no transfer is in flight.
// Timing:
//   The lanes update their sums on the input transfer; compare and merge
//   results load into the output register when that register can advance.
//   Throughput 1 item per cycle while out_ready is high; the lane sum adds
//   and the slot pointer are loops. With out_ready low the output holds,
//   one more can sit in the lane stage; in_ready drops only when both are full.
// Reset: synchronous, active low. Clears windows, sums, slot pointer, the
//   pipeline valids and sets thresholds to 10 and 500.
`timescale 1ns / 1ps

module dual_boxcar_beacon_direction #(
  parameter int WINDOW = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bbd_pkg::SAMPLE_W-1:0]   in_left_sample,
  input  logic [bbd_pkg::SAMPLE_W-1:0]   in_right_sample,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_direction,
  output logic                           out_arrived,
  output logic [bbd_pkg::SUM_OUT_W-1:0]  out_left_sum,
  output logic [bbd_pkg::SUM_OUT_W-1:0]  out_right_sum,
  // config write port
  input  logic                           cfg_we,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbd_pkg::SAMPLE_W-1:0]   cfg_data
);
  import bbd_pkg::*;

  // full-precision sum width: holds 1023*WINDOW
  localparam int SUM_W  = $clog2(((1 << SAMPLE_W) - 1) * WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SUM_W-1:0]  WIN_K     = SUM_W'(WINDOW);
  localparam logic [SUM_W-1:0]  DET_LIM_0 = SUM_W'(DET_THR_RESET * WINDOW);
  localparam logic [SUM_W-1:0]  ARR_LIM_0 = SUM_W'(ARR_THR_RESET * WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // config: limits kept as threshold*WINDOW
  logic [SUM_W-1:0] det_lim_r;
  logic [SUM_W-1:0] arr_lim_r;
  logic [SUM_W-1:0] cfg_lim_nxt;

  assign cfg_lim_nxt = SUM_W'(cfg_data) * WIN_K;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_lim_r <= DET_LIM_0;
      arr_lim_r <= ARR_LIM_0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DETECT:  det_lim_r <= cfg_lim_nxt;
        REG_ARRIVED: arr_lim_r <= cfg_lim_nxt;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic in_xfer;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  // slot pointer shared by both lanes
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;

  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        slot_r <= slot_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // lanes
  logic [SUM_W-1:0] left_total;
  logic [SUM_W-1:0] right_total;
  bbd_hit_t         left_hits;
  bbd_hit_t         right_hits;

  bbd_lane #(.WINDOW(WINDOW), .SUM_W(SUM_W), .SLOT_W(SLOT_W)) u_lane_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_xfer),
    .slot    (slot_r),
    .sample  (in_left_sample),
    .det_lim (det_lim_r),
    .arr_lim (arr_lim_r),
    .total   (left_total),
    .hits    (left_hits)
  );

  bbd_lane #(.WINDOW(WINDOW), .SUM_W(SUM_W), .SLOT_W(SLOT_W)) u_lane_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_xfer),
    .slot    (slot_r),
    .sample  (in_right_sample),
    .det_lim (det_lim_r),
    .arr_lim (arr_lim_r),
    .total   (right_total),
    .hits    (right_hits)
  );

  // merge
  dir_t merge_dir;
  logic merge_arrived;

  bbd_merge #(.SUM_W(SUM_W)) u_merge (
    .left_hits   (left_hits),
    .right_hits  (right_hits),
    .left_total  (left_total),
    .right_total (right_total),
    .direction   (merge_dir),
    .arrived     (merge_arrived)
  );

  // reported sums: low 13 bits, zero-padded for narrow windows
  logic [SUM_W+SUM_OUT_W-1:0] left_pad;
  logic [SUM_W+SUM_OUT_W-1:0] right_pad;

  assign left_pad  = {{SUM_OUT_W{1'b0}}, left_total};
  assign right_pad = {{SUM_OUT_W{1'b0}}, right_total};

  // output register
  dir_t                 out_dir_r;
  logic                 out_arrived_r;
  logic [SUM_OUT_W-1:0] out_left_sum_r;
  logic [SUM_OUT_W-1:0] out_right_sum_r;

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_dir_r       <= merge_dir;
      out_arrived_r   <= merge_arrived;
      out_left_sum_r  <= left_pad[SUM_OUT_W-1:0];
      out_right_sum_r <= right_pad[SUM_OUT_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_direction = out_dir_r;
  assign out_arrived   = out_arrived_r;
  assign out_left_sum  = out_left_sum_r;
  assign out_right_sum = out_right_sum_r;

endmodule

FILE: hw/rtl/bbd_checker.sv
// Port-level checks for the dual boxcar beacon direction block.
`timescale 1ns / 1ps

module bbd_port_checks #(
  parameter int WINDOW = 5
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_direction,
  input logic                           out_arrived,
  input logic [bbd_pkg::SUM_OUT_W-1:0]  out_left_sum,
  input logic [bbd_pkg::SUM_OUT_W-1:0]  out_right_sum
);
  import bbd_pkg::*;

  // sums are reported unmasked up to this window depth
  localparam bit NO_WRAP = (WINDOW <= 8);

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_direction)
      && $stable(out_arrived) && $stable(out_left_sum) && $stable(out_right_sum))
    else $error("stalled result changed");

  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_direction == DIR_FRONT || out_direction == DIR_LEFT
      || out_direction == DIR_RIGHT))
    else $error("invalid direction code");

  a_hit_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NO_WRAP && (out_direction != DIR_FRONT || out_arrived)
      |-> (out_left_sum != '0 || out_right_sum != '0))
    else $error("detection reported with empty windows");

endmodule

bind dual_boxcar_beacon_direction bbd_port_checks #(.WINDOW(WINDOW)) u_bbd_port_checks (.*);
